// ----- hw/rtl/canonical_huffman_block_decoder_unit_defines.svh -----
// Assertion macros shared by the checker of the canonical Huffman block decoder.
`ifndef CANONICAL_HUFFMAN_BLOCK_DECODER_UNIT_DEFINES_SVH
`define CANONICAL_HUFFMAN_BLOCK_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CHBD_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("chbd assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CHBD_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("chbd assertion failed");

`endif

// ----- hw/rtl/chbd_pkg.sv -----
// Package with the result status codes and parse phase codes of the Huffman block decoder.
`timescale 1ns / 1ps

package chbd_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 6;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [1:0]        status_type;
   typedef logic [2:0]        phase_type;

   localparam status_type ST_SYMBOL   = 2'd0;
   localparam status_type ST_DONE     = 2'd1;
   localparam status_type ST_BAD_PATH = 2'd2;
   localparam status_type ST_BAD_TAB  = 2'd3;

   localparam phase_type PH_COUNT = 3'd0;
   localparam phase_type PH_SIZE  = 3'd1;
   localparam phase_type PH_SYM   = 3'd2;
   localparam phase_type PH_LEN   = 3'd3;
   localparam phase_type PH_DATA  = 3'd4;
   localparam phase_type PH_SKIP  = 3'd5;

endpackage

// ----- hw/rtl/canonical_huffman_block_decoder_unit.sv -----
// Top level of the canonical Huffman block decoder: parser, table builder and bit decoder.
`timescale 1ns / 1ps

// The block takes one stream byte per beat and is busy until that byte's results are
// queued. A header or table byte passes the parse state and then the flush state before
// the next byte can be taken. The last table byte starts the table build, which sweeps
// the 256-entry length memory twice and walks the code lengths once. A full data byte
// passes the parse state, then for each of its eight bits a step in the shared compare
// unit and either the prefix check or the symbol memory read, then the end-of-block
// step when it ends the block, and the flush state. Back pressure on the output can
// stall the steps that push a result. Each result waits in a one-deep holding stage,
// so the beat that ends the results of a byte can carry tlast.
module canonical_huffman_block_decoder_unit #(
   parameter int MAX_CODE_LEN  = 32,
   parameter int ALPHABET_SIZE = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  chbd_pkg::byte_type   req_tdata,   // [7:0] data_byte
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output chbd_pkg::byte_type   rsp_tdata,   // [7:0] symbol
   output chbd_pkg::status_type rsp_tuser,   // [1:0] status
   output logic                 rsp_tlast
);
   import chbd_pkg::*;

   localparam int LIDX = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
   localparam logic [LEN_W-1:0] MAXL = LEN_W'(MAX_CODE_LEN);
   localparam logic [15:0] ALPHA16 = 16'(ALPHABET_SIZE);
   localparam logic [8:0]  ALPHA9  = 9'(ALPHABET_SIZE);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_PARSE   = 4'd1;
   localparam logic [3:0] S_B1      = 4'd2;
   localparam logic [3:0] S_B2      = 4'd3;
   localparam logic [3:0] S_B3      = 4'd4;
   localparam logic [3:0] S_ENDTAB  = 4'd5;
   localparam logic [3:0] S_ENDTAB2 = 4'd6;
   localparam logic [3:0] S_ENDBLK  = 4'd7;
   localparam logic [3:0] S_BIT     = 4'd8;
   localparam logic [3:0] S_PRE     = 4'd9;
   localparam logic [3:0] S_SYM     = 4'd10;
   localparam logic [3:0] S_SYMOUT  = 4'd11;
   localparam logic [3:0] S_FLUSH   = 4'd12;

   logic [3:0]       state_ff, state_in;
   byte_type         byte_ff, byte_in;
   phase_type        phase_ff, phase_in;
   logic [1:0]       fbi_ff, fbi_in;
   logic [31:0]      total_ff, total_in;
   logic [15:0]      tet_ff, tet_in;
   logic [15:0]      seen_ff, seen_in;
   byte_type         psym_ff, psym_in;
   logic [31:0]      consumed_ff, consumed_in;
   logic [31:0]      pcode_ff, pcode_in;
   logic [LEN_W-1:0] plen_ff, plen_in;
   logic [3:0]       rem_ff, rem_in;
   logic [8:0]       sweep_ff, sweep_in;
   logic [LEN_W-1:0] lc_ff, lc_in;
   logic [8:0]       rank_ff, rank_in;
   logic [33:0]      code_ff, code_in;
   logic             bad_ff, bad_in;
   logic [LEN_W-1:0] ml_ff, ml_in;
   logic [32:0]      last_ff, last_in;
   byte_type         ridx_ff, ridx_in;
   logic             pend_v_ff, pend_v_in;
   byte_type         pend_sym_ff, pend_sym_in;
   status_type       pend_st_ff, pend_st_in;
   logic             rsp_v_ff, rsp_v_in;
   byte_type         rsp_sym_ff, rsp_sym_in;
   status_type       rsp_st_ff, rsp_st_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [LEN_W-1:0] len_mem_ff [256];
   logic [LEN_W-1:0] lm_q_ff;
   logic [255:0]     lvalid_ff;
   logic             lv_q_ff;
   byte_type         sr_mem_ff [256];
   byte_type         sr_q_ff;
   logic [8:0]       cnt_ff [MAX_CODE_LEN];
   logic [31:0]      fc_ff  [MAX_CODE_LEN];
   logic [8:0]       fr_ff  [MAX_CODE_LEN];
   logic [8:0]       nr_ff  [MAX_CODE_LEN];

   logic             lm_we, lv_clr, cnt_clr, cnt_we, b2_we, fc_we, sr_we;
   logic [LEN_W-1:0] lm_wdata;
   logic [LIDX-1:0]  bidx, jidx, didx;
   logic [LEN_W-1:0] blen;
   logic             blen_ok;
   logic [8:0]       sprev;
   logic             push_v, push_ok, out_free;
   byte_type         push_sym;
   status_type       push_st;
   logic             cur_bit, d_inr, d_match, keep;
   logic [31:0]      p_n, diff;
   logic [LEN_W-1:0] l_n;
   logic [33:0]      code_n;
   logic [15:0]      tet_n;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_sym_ff;
   assign rsp_tuser  = rsp_st_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign blen    = lv_q_ff ? lm_q_ff : '0;
   assign blen_ok = (blen != '0) && (blen <= MAXL);
   assign bidx    = LIDX'(blen - 6'd1);
   assign sprev   = sweep_ff - 9'd1;
   assign jidx    = LIDX'(lc_ff - 6'd1);
   assign code_n  = code_ff + 34'(cnt_ff[jidx]);

   assign cur_bit = byte_ff[3'(rem_ff - 4'd1)];
   assign p_n     = {pcode_ff[30:0], cur_bit};
   assign l_n     = plen_ff + 6'd1;
   assign didx    = LIDX'(l_n - 6'd1);
   assign d_inr   = (l_n != '0) && (l_n <= MAXL);
   assign diff    = p_n - fc_ff[didx];
   assign d_match = d_inr && (cnt_ff[didx] != '0) && (p_n >= fc_ff[didx])
                    && (diff[31:9] == '0) && (diff[8:0] < cnt_ff[didx]);
   assign keep    = (ml_ff != '0) && (plen_ff != '0) && (plen_ff < ml_ff)
                    && ({1'b0, pcode_ff} <= (last_ff >> (ml_ff - plen_ff)));
   assign tet_n   = {byte_ff, tet_ff[7:0]};

   assign out_free = !rsp_v_ff || rsp_tready;
   assign push_ok  = !pend_v_ff || out_free;

   always_comb begin
      state_in    = state_ff;
      byte_in     = byte_ff;
      phase_in    = phase_ff;
      fbi_in      = fbi_ff;
      total_in    = total_ff;
      tet_in      = tet_ff;
      seen_in     = seen_ff;
      psym_in     = psym_ff;
      consumed_in = consumed_ff;
      pcode_in    = pcode_ff;
      plen_in     = plen_ff;
      rem_in      = rem_ff;
      sweep_in    = sweep_ff;
      lc_in       = lc_ff;
      rank_in     = rank_ff;
      code_in     = code_ff;
      bad_in      = bad_ff;
      ml_in       = ml_ff;
      last_in     = last_ff;
      ridx_in     = ridx_ff;
      lm_we       = 1'b0;
      lm_wdata    = (byte_ff > 8'd63) ? 6'd63 : byte_ff[5:0];
      lv_clr      = 1'b0;
      cnt_clr     = 1'b0;
      cnt_we      = 1'b0;
      b2_we       = 1'b0;
      fc_we       = 1'b0;
      sr_we       = 1'b0;
      push_v      = 1'b0;
      push_sym    = '0;
      push_st     = ST_SYMBOL;
      pend_v_in   = pend_v_ff;
      pend_sym_in = pend_sym_ff;
      pend_st_in  = pend_st_ff;
      rsp_v_in    = rsp_v_ff && !rsp_tready;
      rsp_sym_in  = rsp_sym_ff;
      rsp_st_in   = rsp_st_ff;
      rsp_last_in = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               byte_in  = req_tdata;
               state_in = S_PARSE;
            end
         end
         S_PARSE: begin
            state_in = S_FLUSH;
            case (phase_ff)
               PH_SIZE: begin
                  if (fbi_ff == 2'd0) begin
                     tet_in = {8'd0, byte_ff};
                     fbi_in = 2'd1;
                  end else begin
                     tet_in = tet_n;
                     fbi_in = 2'd0;
                     if (tet_n > ALPHA16) begin
                        push_v   = 1'b1;
                        push_st  = ST_BAD_TAB;
                        phase_in = PH_COUNT;
                     end else begin
                        lv_clr  = 1'b1;
                        seen_in = '0;
                        if (tet_n == '0) begin
                           state_in = S_B1;
                        end else begin
                           phase_in = PH_SYM;
                        end
                     end
                  end
               end
               PH_SYM: begin
                  psym_in  = byte_ff;
                  phase_in = PH_LEN;
               end
               PH_LEN: begin
                  lm_we   = 1'b1;
                  seen_in = seen_ff + 16'd1;
                  if (seen_ff + 16'd1 >= tet_ff) begin
                     state_in = S_B1;
                  end else begin
                     phase_in = PH_SYM;
                  end
               end
               PH_DATA: begin
                  rem_in   = 4'd8;
                  state_in = S_BIT;
               end
               PH_SKIP: begin
                  if ((total_ff - consumed_ff <= 32'd8) || (consumed_ff > total_ff)) begin
                     consumed_in = total_ff;
                     state_in    = S_ENDBLK;
                  end else begin
                     consumed_in = consumed_ff + 32'd8;
                  end
               end
               default: begin
                  if (fbi_ff == 2'd0) begin
                     total_in = {24'd0, byte_ff};
                  end else begin
                     total_in = total_ff | (32'(byte_ff) << {fbi_ff, 3'b000});
                  end
                  if (fbi_ff == 2'd3) begin
                     fbi_in   = 2'd0;
                     phase_in = PH_SIZE;
                  end else begin
                     fbi_in   = fbi_ff + 2'd1;
                     phase_in = PH_COUNT;
                  end
               end
            endcase
            if (state_in == S_B1) begin
               sweep_in = '0;
               cnt_clr  = 1'b1;
               bad_in   = 1'b0;
               rank_in  = '0;
               code_in  = '0;
               ml_in    = '0;
            end
         end
         S_B1: begin
            if (sweep_ff != '0) begin
               if (blen > MAXL) begin
                  bad_in = 1'b1;
               end
               if ((blen != '0) && (sprev >= ALPHA9)) begin
                  bad_in = 1'b1;
               end
               cnt_we = blen_ok;
            end
            sweep_in = sweep_ff + 9'd1;
            if (sweep_ff == 9'd256) begin
               lc_in    = 6'd1;
               state_in = S_B2;
            end
         end
         S_B2: begin
            b2_we   = 1'b1;
            rank_in = rank_ff + cnt_ff[jidx];
            if (!bad_ff) begin
               fc_we   = 1'b1;
               code_in = code_n << 1;
               if (code_n > (34'd1 << lc_ff)) begin
                  bad_in = 1'b1;
               end
               if (cnt_ff[jidx] != '0) begin
                  ml_in   = lc_ff;
                  last_in = 33'(code_n - 34'd1);
               end
            end
            lc_in = lc_ff + 6'd1;
            if (lc_ff == MAXL) begin
               sweep_in = '0;
               state_in = S_B3;
            end
         end
         S_B3: begin
            sr_we    = (sweep_ff != '0) && blen_ok;
            sweep_in = sweep_ff + 9'd1;
            if (sweep_ff == 9'd256) begin
               state_in = S_ENDTAB;
            end
         end
         S_ENDTAB: begin
            consumed_in = '0;
            pcode_in    = '0;
            plen_in     = '0;
            if (bad_ff) begin
               push_v  = 1'b1;
               push_st = ST_BAD_TAB;
               if (push_ok) begin
                  state_in = S_ENDTAB2;
               end
            end else begin
               state_in = S_ENDTAB2;
            end
         end
         S_ENDTAB2: begin
            if (total_ff == '0) begin
               state_in = S_ENDBLK;
            end else begin
               phase_in = bad_ff ? PH_SKIP : PH_DATA;
               state_in = S_FLUSH;
            end
         end
         S_ENDBLK: begin
            push_v  = 1'b1;
            push_st = ST_DONE;
            if (push_ok) begin
               phase_in = PH_COUNT;
               fbi_in   = 2'd0;
               pcode_in = '0;
               plen_in  = '0;
               state_in = S_FLUSH;
            end
         end
         S_BIT: begin
            if ((rem_ff == '0) || (consumed_ff >= total_ff)) begin
               state_in = (consumed_ff >= total_ff) ? S_ENDBLK : S_FLUSH;
            end else begin
               rem_in      = rem_ff - 4'd1;
               consumed_in = consumed_ff + 32'd1;
               pcode_in    = p_n;
               plen_in     = l_n;
               ridx_in     = 8'(fr_ff[didx] + diff[8:0]);
               state_in    = d_match ? S_SYM : S_PRE;
            end
         end
         S_PRE: begin
            if (keep) begin
               state_in = S_BIT;
            end else begin
               push_v  = 1'b1;
               push_st = ST_BAD_PATH;
               if (push_ok) begin
                  pcode_in = '0;
                  plen_in  = '0;
                  state_in = S_BIT;
               end
            end
         end
         S_SYM: begin
            state_in = S_SYMOUT;
         end
         S_SYMOUT: begin
            push_v   = 1'b1;
            push_sym = sr_q_ff;
            push_st  = ST_SYMBOL;
            if (push_ok) begin
               pcode_in = '0;
               plen_in  = '0;
               state_in = S_BIT;
            end
         end
         S_FLUSH: begin
            if (!pend_v_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_v_in    = 1'b1;
               rsp_sym_in  = pend_sym_ff;
               rsp_st_in   = pend_st_ff;
               rsp_last_in = 1'b1;
               pend_v_in   = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (push_v && push_ok) begin
         if (pend_v_ff) begin
            rsp_v_in    = 1'b1;
            rsp_sym_in  = pend_sym_ff;
            rsp_st_in   = pend_st_ff;
            rsp_last_in = 1'b0;
         end
         pend_v_in   = 1'b1;
         pend_sym_in = push_sym;
         pend_st_in  = push_st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         phase_ff    <= PH_COUNT;
         fbi_ff      <= '0;
         total_ff    <= '0;
         tet_ff      <= '0;
         seen_ff     <= '0;
         consumed_ff <= '0;
         pcode_ff    <= '0;
         plen_ff     <= '0;
         pend_v_ff   <= 1'b0;
         rsp_v_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         fbi_ff      <= fbi_in;
         total_ff    <= total_in;
         tet_ff      <= tet_in;
         seen_ff     <= seen_in;
         consumed_ff <= consumed_in;
         pcode_ff    <= pcode_in;
         plen_ff     <= plen_in;
         pend_v_ff   <= pend_v_in;
         rsp_v_ff    <= rsp_v_in;
      end
      byte_ff     <= byte_in;
      psym_ff     <= psym_in;
      rem_ff      <= rem_in;
      sweep_ff    <= sweep_in;
      lc_ff       <= lc_in;
      rank_ff     <= rank_in;
      code_ff     <= code_in;
      bad_ff      <= bad_in;
      ml_ff       <= ml_in;
      last_ff     <= last_in;
      ridx_ff     <= ridx_in;
      pend_sym_ff <= pend_sym_in;
      pend_st_ff  <= pend_st_in;
      rsp_sym_ff  <= rsp_sym_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (lm_we) begin
         len_mem_ff[psym_ff] <= lm_wdata;
      end
      lm_q_ff <= len_mem_ff[sweep_ff[7:0]];
      lv_q_ff <= lvalid_ff[sweep_ff[7:0]];
   end

   always_ff @(posedge clock) begin
      if (reset || lv_clr) begin
         lvalid_ff <= '0;
      end else if (lm_we) begin
         lvalid_ff[psym_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (sr_we) begin
         sr_mem_ff[nr_ff[bidx][7:0]] <= sprev[7:0];
      end
      sr_q_ff <= sr_mem_ff[ridx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset || cnt_clr) begin
         for (int i = 0; i < MAX_CODE_LEN; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (cnt_we) begin
         cnt_ff[bidx] <= cnt_ff[bidx] + 9'd1;
      end
      if (b2_we) begin
         fr_ff[jidx] <= rank_ff;
         nr_ff[jidx] <= rank_ff;
      end else if (sr_we) begin
         nr_ff[bidx] <= nr_ff[bidx] + 9'd1;
      end
      if (fc_we) begin
         fc_ff[jidx] <= code_ff[31:0];
      end
   end

endmodule

// ----- hw/rtl/chbd_checker.sv -----
// Port-level checker of the Huffman block decoder, bound to the top level.
`timescale 1ns / 1ps
`include "canonical_huffman_block_decoder_unit_defines.svh"

module chbd_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input chbd_pkg::byte_type   req_tdata,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input chbd_pkg::byte_type   rsp_tdata,
   input chbd_pkg::status_type rsp_tuser,
   input logic                 rsp_tlast
);
   import chbd_pkg::*;

   logic req_beat;
   assign req_beat = req_tvalid && req_tready && (req_tdata == req_tdata);

   `CHBD_ASSERT_NXT(a_busy_after_beat, req_beat, !req_tready)
   `CHBD_ASSERT_IMP(a_done_is_last, rsp_tvalid && (rsp_tuser == ST_DONE), rsp_tlast)
   `CHBD_ASSERT_IMP(a_marker_no_symbol, rsp_tvalid && (rsp_tuser != ST_SYMBOL), rsp_tdata == '0)
   `CHBD_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind canonical_huffman_block_decoder_unit chbd_checker u_chbd_checker (.*);

// ----- bench/tb_canonical_huffman_block_decoder_unit.sv -----
// Self-checking testbench for the canonical Huffman block decoder with a stream-level predictor.
`timescale 1ns / 1ps

import chbd_pkg::*;

typedef struct packed {
   byte_type   sym;
   status_type st;
   logic       last;
} huff_result_type;

class huff_scoreboard;
   huff_result_type expected_q[$];
   int errors;
   int results_seen;
   int blocks_done;

   bit [2:0]  phase;
   bit [1:0]  field_idx;
   bit [31:0] bit_total;
   bit [15:0] entry_total;
   bit [15:0] entries_seen;
   byte_type  pend_sym;
   bit [5:0]  sym_len[256];
   byte_type  rank_sym[256];
   int        len_count[33];
   bit [31:0] len_first_code[33];
   bit [15:0] len_first_rank[33];
   bit [31:0] bits_used;
   bit [31:0] code_acc;
   bit [5:0]  code_len;
   huff_result_type step_q[$];

   function new();
      errors = 0;
      results_seen = 0;
      blocks_done = 0;
      phase = PH_COUNT;
      field_idx = 0;
      bit_total = 0;
      entry_total = 0;
      entries_seen = 0;
      pend_sym = 0;
      bits_used = 0;
      code_acc = 0;
      code_len = 0;
      foreach (sym_len[i]) sym_len[i] = 0;
      foreach (rank_sym[i]) rank_sym[i] = 0;
      foreach (len_count[i]) begin
         len_count[i] = 0;
         len_first_code[i] = 0;
         len_first_rank[i] = 0;
      end
   endfunction

   function void push(byte_type s, status_type st);
      huff_result_type r;
      if (step_q.size() >= 9) return;
      r.sym = s;
      r.st = st;
      r.last = 0;
      step_q.insert(step_q.size(), r);
   endfunction

   function bit rebuild_codes();
      bit bad;
      int rank;
      bit [63:0] code;
      bad = 0;
      rank = 0;
      code = 0;
      foreach (len_count[i]) len_count[i] = 0;
      for (int s = 0; s < 256; s++)
         if (sym_len[s] > 32) bad = 1;
      for (int l = 1; l <= 32; l++) begin
         len_first_rank[l] = rank[15:0];
         for (int s = 0; s < 256; s++)
            if (sym_len[s] == l) begin
               if (rank < 256) rank_sym[rank] = s[7:0];
               rank++;
               len_count[l]++;
            end
      end
      for (int l = 1; l <= 32 && !bad; l++) begin
         len_first_code[l] = code[31:0];
         code += len_count[l];
         if (code > (64'd1 << l)) bad = 1;
         code = code << 1;
      end
      return bad;
   endfunction

   function void take_bit(bit b);
      int l, ml;
      bit [63:0] p, f, lastc;
      code_acc = {code_acc[30:0], b};
      code_len = code_len + 6'd1;
      l = code_len;
      p = code_acc;
      if (l >= 1 && l <= 32) begin
         f = len_first_code[l];
         if (len_count[l] != 0 && p >= f && p - f < len_count[l]) begin
            push(rank_sym[(len_first_rank[l] + (p - f)) & 255], ST_SYMBOL);
            code_acc = 0;
            code_len = 0;
            return;
         end
      end
      ml = 0;
      for (int k = 1; k <= 32; k++)
         if (len_count[k] != 0) ml = k;
      if (ml != 0 && l >= 1 && l < ml) begin
         lastc = len_first_code[ml] + len_count[ml] - 1;
         if (p <= (lastc >> (ml - l))) return;
      end
      push(0, ST_BAD_PATH);
      code_acc = 0;
      code_len = 0;
   endfunction

   function void close_block();
      push(0, ST_DONE);
      blocks_done++;
      phase = PH_COUNT;
      field_idx = 0;
      code_acc = 0;
      code_len = 0;
   endfunction

   function void close_table();
      bit bad;
      bad = rebuild_codes();
      bits_used = 0;
      code_acc = 0;
      code_len = 0;
      if (bad) push(0, ST_BAD_TAB);
      if (bit_total == 0) close_block();
      else phase = bad ? PH_SKIP : PH_DATA;
   endfunction

   function void note_byte(byte_type b);
      step_q.delete();
      case (phase)
         PH_SIZE: begin
            if (field_idx == 0) begin
               entry_total = {8'd0, b};
               field_idx = 1;
            end else begin
               entry_total[15:8] = b;
               field_idx = 0;
               if (entry_total > 256) begin
                  push(0, ST_BAD_TAB);
                  phase = PH_COUNT;
               end else begin
                  foreach (sym_len[i]) sym_len[i] = 0;
                  entries_seen = 0;
                  if (entry_total == 0) close_table();
                  else phase = PH_SYM;
               end
            end
         end
         PH_SYM: begin
            pend_sym = b;
            phase = PH_LEN;
         end
         PH_LEN: begin
            sym_len[pend_sym] = (b > 63) ? 6'd63 : b[5:0];
            entries_seen++;
            if (entries_seen >= entry_total) close_table();
            else phase = PH_SYM;
         end
         PH_DATA: begin
            for (int i = 7; i >= 0 && bits_used < bit_total; i--) begin
               take_bit(b[i]);
               bits_used++;
            end
            if (bits_used >= bit_total) close_block();
         end
         PH_SKIP: begin
            if (bit_total - bits_used <= 32'd8 || bits_used > bit_total) begin
               bits_used = bit_total;
               close_block();
            end else begin
               bits_used += 8;
            end
         end
         default: begin
            if (field_idx == 0) bit_total = {24'd0, b};
            else bit_total |= 32'(b) << (8 * field_idx);
            if (field_idx == 3) begin
               field_idx = 0;
               phase = PH_SIZE;
            end else begin
               field_idx++;
               phase = PH_COUNT;
            end
         end
      endcase
      if (step_q.size() > 0) step_q[step_q.size()-1].last = 1;
      foreach (step_q[i]) expected_q.insert(expected_q.size(), step_q[i]);
   endfunction

   task report(string what);
      $display("ERROR at %0t: %s", $realtime, what);
      errors++;
   endtask

   task check_result(byte_type sym, status_type st, logic last);
      huff_result_type e;
      results_seen++;
      if (expected_q.size() == 0) begin
         report($sformatf("unexpected result sym=%0d status=%0d", sym, st));
         return;
      end
      e = expected_q.pop_front();
      if (sym !== e.sym || st !== e.st || last !== e.last)
         report($sformatf("got sym=%0d status=%0d last=%0b, want %0d %0d %0b",
                          sym, st, last, e.sym, e.st, e.last));
   endtask
endclass

module tb_canonical_huffman_block_decoder_unit;
   logic       clock = 0;
   logic       reset = 1;
   logic       req_tvalid = 0;
   logic       req_tready;
   byte_type   req_tdata = 0;
   logic       rsp_tvalid;
   logic       rsp_tready = 0;
   byte_type   rsp_tdata;
   status_type rsp_tuser;
   logic       rsp_tlast;

   huff_scoreboard sb = new();
   int send_idle = 0;
   int recv_idle = 0;
   int bytes_sent = 0;
   int cycles = 0;
   byte_type stream_q[$];

   canonical_huffman_block_decoder_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 500000) begin
         $display("Timed out with %0d results still expected.", sb.expected_q.size());
         $display("canonical_huffman_block_decoder_unit: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   task send_byte(input byte_type b);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(b);
      bytes_sent++;
   endtask

   task send_stream();
      while (stream_q.size() > 0) send_byte(stream_q.pop_front());
   endtask

   task queue_byte(input byte_type b);
      stream_q.insert(stream_q.size(), b);
   endtask

   task add_header(input bit [31:0] nbits, input bit [15:0] nent);
      for (int i = 0; i < 4; i++) queue_byte(nbits[8*i +: 8]);
      queue_byte(nent[7:0]);
      queue_byte(nent[15:8]);
   endtask

   task make_block();
      int kind, n, nbits, pick, tmp;
      int lens[$];
      kind = $urandom_range(99);
      if (kind < 6) begin
         add_header(32'($urandom_range(0, 40)), 16'($urandom_range(257, 65535)));
         return;
      end
      lens.delete();
      if (kind < 10) begin
         n = 0;
      end else if (kind < 80) begin
         n = $urandom_range(2, 9);
         lens.insert(lens.size(), 1);
         lens.insert(lens.size(), 1);
         while (lens.size() < n) begin
            pick = $urandom_range(0, lens.size() - 1);
            tmp = lens[pick] + 1;
            lens.delete(pick);
            lens.insert(lens.size(), tmp);
            lens.insert(lens.size(), tmp);
         end
         if (kind > 70) void'(lens.pop_front());
      end else begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            tmp = pick < 10 ? 0 : pick < 18 ? $urandom_range(33, 255) :
                  pick < 25 ? 32 : $urandom_range(1, 4);
            lens.insert(lens.size(), tmp);
         end
      end
      nbits = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 40);
      add_header(32'(nbits), 16'(lens.size()));
      foreach (lens[i]) begin
         queue_byte(8'($urandom_range(0, 255)));
         queue_byte(8'(lens[i]));
      end
      for (int i = 0; i < (nbits + 7) / 8; i++) queue_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      add_header(10, 3);
      queue_byte(8'h41); queue_byte(8'd1);
      queue_byte(8'h42); queue_byte(8'd2);
      queue_byte(8'h43); queue_byte(8'd2);
      queue_byte(8'b0101_1100); queue_byte(8'b1100_0000);
      add_header(0, 257);
      add_header(0, 0);
      send_stream();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 21 : (ph == 1) ? 45 : 0;
         recv_idle = (ph == 0) ? 45 : (ph == 1) ? 21 : 0;
         while (bytes_sent < 26 + 60 * (ph + 1)) begin
            make_block();
            send_stream();
         end
      end
      req_tvalid <= 0;
      recv_idle = 0;

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (800) @(posedge clock);

      $display("Sent %0d stream bytes, checked %0d results over %0d finished blocks.",
               bytes_sent, sb.results_seen, sb.blocks_done);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("canonical_huffman_block_decoder_unit: match");
      else
         $display("canonical_huffman_block_decoder_unit: mismatch");
      $finish;
   end
endmodule

// ----- canonical_huffman_block_decoder_unit.f -----
+incdir+hw/rtl
hw/rtl/chbd_pkg.sv
hw/rtl/canonical_huffman_block_decoder_unit.sv
hw/rtl/chbd_checker.sv
bench/tb_canonical_huffman_block_decoder_unit.sv
